// ===== rtl/oriented_chamfer_pixel_cost_defines.svh =====
// Assertion macros shared by the oriented chamfer cost block.
`ifndef ORIENTED_CHAMFER_PIXEL_COST_DEFINES_SVH
`define ORIENTED_CHAMFER_PIXEL_COST_DEFINES_SVH

// Condition implies consequence in the same cycle.
`define OCC_ASSERT_NOW(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
    else $error(msg);

// Condition implies consequence in the next cycle.
`define OCC_ASSERT_NEXT(label, clk, rst_n, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/occ_pkg.sv =====
// Package with shared types, constants and tables of the oriented chamfer cost block.
`timescale 1ns / 1ps
package occ_pkg;

  localparam int MAX_CHANNELS = 32;
  localparam int ANGLE_BITS   = 16;
  localparam int CORDIC_STEPS = 28;
  localparam int QUEUE_DEPTH  = 2;
  localparam int CH_W         = 5;
  localparam int CNT_W        = 6;
  localparam int COST_W       = 16;
  localparam int CW_W         = 36;
  localparam int ZW_W         = 34;

  localparam logic [15:0] ONE_Q15   = 16'h8000;
  localparam logic [15:0] HALF_TURN = 16'h8000;

  typedef enum logic [1:0] {
    CFG_NEAR_TOL  = 2'd0,
    CFG_FAR_THR   = 2'd1,
    CFG_CHAN_CNT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [1:0] {
    FE_IDLE,
    FE_RUN,
    FE_PUSH
  } fe_state_t;

  typedef struct packed {
    logic        far;
    logic [15:0] cham;
    logic [15:0] ang;
  } qent_t;

  function automatic logic signed [ZW_W-1:0] atan_val(input logic [4:0] i);
    logic signed [ZW_W-1:0] v;
    unique case (i)
      5'd0:  v = 34'sd536870912;
      5'd1:  v = 34'sd316933406;
      5'd2:  v = 34'sd167458907;
      5'd3:  v = 34'sd85004756;
      5'd4:  v = 34'sd42667331;
      5'd5:  v = 34'sd21354465;
      5'd6:  v = 34'sd10679838;
      5'd7:  v = 34'sd5340245;
      5'd8:  v = 34'sd2670163;
      5'd9:  v = 34'sd1335087;
      5'd10: v = 34'sd667544;
      5'd11: v = 34'sd333772;
      5'd12: v = 34'sd166886;
      5'd13: v = 34'sd83443;
      5'd14: v = 34'sd41722;
      5'd15: v = 34'sd20861;
      5'd16: v = 34'sd10430;
      5'd17: v = 34'sd5215;
      5'd18: v = 34'sd2608;
      5'd19: v = 34'sd1304;
      5'd20: v = 34'sd652;
      5'd21: v = 34'sd326;
      5'd22: v = 34'sd163;
      5'd23: v = 34'sd81;
      5'd24: v = 34'sd41;
      5'd25: v = 34'sd20;
      5'd26: v = 34'sd10;
      5'd27: v = 34'sd5;
      default: v = '0;
    endcase
    return v;
  endfunction

  // Quotient of a full turn (65536) by the channel count.
  function automatic logic [15:0] step_quo(input logic [CNT_W-1:0] n);
    logic [15:0] v;
    unique case (n)
      6'd2:  v = 16'd32768;  6'd3:  v = 16'd21845;  6'd4:  v = 16'd16384;
      6'd5:  v = 16'd13107;  6'd6:  v = 16'd10922;  6'd7:  v = 16'd9362;
      6'd8:  v = 16'd8192;   6'd9:  v = 16'd7281;   6'd10: v = 16'd6553;
      6'd11: v = 16'd5957;   6'd12: v = 16'd5461;   6'd13: v = 16'd5041;
      6'd14: v = 16'd4681;   6'd15: v = 16'd4369;   6'd16: v = 16'd4096;
      6'd17: v = 16'd3855;   6'd18: v = 16'd3640;   6'd19: v = 16'd3449;
      6'd20: v = 16'd3276;   6'd21: v = 16'd3120;   6'd22: v = 16'd2978;
      6'd23: v = 16'd2849;   6'd24: v = 16'd2730;   6'd25: v = 16'd2621;
      6'd26: v = 16'd2520;   6'd27: v = 16'd2427;   6'd28: v = 16'd2340;
      6'd29: v = 16'd2259;   6'd30: v = 16'd2184;   6'd31: v = 16'd2114;
      6'd32: v = 16'd2048;
      default: v = 16'd32768;
    endcase
    return v;
  endfunction

  // Remainder of a full turn (65536) by the channel count.
  function automatic logic [CNT_W-1:0] step_rem(input logic [CNT_W-1:0] n);
    logic [CNT_W-1:0] v;
    unique case (n)
      6'd3, 6'd5, 6'd15, 6'd17: v = 6'd1;
      6'd7, 6'd14, 6'd31:       v = 6'd2;
      6'd13:                    v = 6'd3;
      6'd6, 6'd12:              v = 6'd4;
      6'd19:                    v = 6'd5;
      6'd10:                    v = 6'd6;
      6'd9, 6'd27:              v = 6'd7;
      6'd11, 6'd23:             v = 6'd9;
      6'd25:                    v = 6'd11;
      6'd18, 6'd20, 6'd21, 6'd24, 6'd26, 6'd28, 6'd30: v = 6'd16;
      6'd22:                    v = 6'd20;
      6'd29:                    v = 6'd25;
      default:                  v = 6'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== rtl/oriented_chamfer_pixel_cost.sv =====
// Top level of the oriented chamfer cost block: configuration, front, queue and back.
`timescale 1ns / 1ps
`include "oriented_chamfer_pixel_cost_defines.svh"
// Each pixel gives one result per orientation channel, channel_count of them (clamped to
// 2..32), one per cycle from the output register while out_tready is high. The front part
// loads a pixel, then runs the CORDIC at two steps and the divider at one quotient bit per
// cycle; it takes a new pixel only as it hands the last one to the queue, which overlaps the
// next load. Configuration is taken at any time but may only change while the block holds
// no pixel.
module oriented_chamfer_pixel_cost import occ_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [47:0] in_tdata,   // signed_distance, gradient_x, gradient_y
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // channel_index, chamfer_cost, orient_cost, zero fill
  output logic        out_tlast,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  logic [14:0] near_tol_r, far_thr_r;
  logic [CNT_W-1:0] chan_cnt_r, n_clamp;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      near_tol_r <= 15'd256;
      far_thr_r  <= 15'd2560;
      chan_cnt_r <= 6'd18;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_idx_t'(cfg_index))
        CFG_NEAR_TOL: near_tol_r <= cfg_data[14:0];
        CFG_FAR_THR:  far_thr_r  <= cfg_data[14:0];
        CFG_CHAN_CNT: chan_cnt_r <= cfg_data[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (chan_cnt_r < 6'd2)                        n_clamp = 6'd2;
    else if (chan_cnt_r > CNT_W'(MAX_CHANNELS))   n_clamp = CNT_W'(MAX_CHANNELS);
    else                                          n_clamp = chan_cnt_r;
  end

  logic f_valid, f_ready, b_valid, b_ready;
  qent_t f_data, b_data;
  logic [CH_W-1:0] ch;
  logic [COST_W-1:0] cham, orient;

  occ_front u_front (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_tvalid), .in_ready(in_tready),
    .sd(in_tdata[15:0]), .gx(in_tdata[31:16]), .gy(in_tdata[47:32]),
    .near_tol(near_tol_r), .thr(far_thr_r),
    .q_valid(f_valid), .q_ready(f_ready), .q_data(f_data)
  );

  occ_queue u_queue (
    .clk(clk), .rst_n(rst_n),
    .wr_valid(f_valid), .wr_ready(f_ready), .wr_data(f_data),
    .rd_valid(b_valid), .rd_ready(b_ready), .rd_data(b_data)
  );

  occ_back u_back (
    .clk(clk), .rst_n(rst_n), .n(n_clamp),
    .q_valid(b_valid), .q_ready(b_ready), .q_data(b_data),
    .out_valid(out_tvalid), .out_ready(out_tready),
    .ch(ch), .cham(cham), .orient(orient), .last(out_tlast)
  );

  assign out_tdata = {3'b000, orient, cham, ch};

  `OCC_ASSERT_NOW(a_last_chan, clk, rst_n, out_tvalid && out_tlast, ch == CH_W'(n_clamp - 6'd1), "last flag on wrong channel")
  `OCC_ASSERT_NOW(a_cost_range, clk, rst_n, out_tvalid, (cham <= ONE_Q15) && (orient <= ONE_Q15), "cost above one")
  `OCC_ASSERT_NEXT(a_no_gap, clk, rst_n, out_tvalid && out_tready && !out_tlast, out_tvalid, "gap inside a pixel")

endmodule

// ===== rtl/occ_front.sv =====
// Front part: accepts a pixel, runs the distance divider and the angle CORDIC.
`timescale 1ns / 1ps
module occ_front import occ_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [15:0] sd,
  input  logic [15:0] gx,
  input  logic [15:0] gy,
  input  logic [14:0] near_tol,
  input  logic [14:0] thr,
  output logic        q_valid,
  input  logic        q_ready,
  output qent_t       q_data
);

  localparam logic [3:0] LAST_CNT = 4'd14;

  fe_state_t st_r, st_nxt;
  logic [3:0] cnt_r;
  logic signed [CW_W-1:0] x_r, y_r;
  logic signed [ZW_W-1:0] z_r;
  logic [15:0] rem_r;
  logic [14:0] quo_r;
  logic near_r, sat_r, far_r, axis_r, axis_zero_r;

  logic in_fire;
  assign in_fire = in_valid && in_ready;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      FE_IDLE: if (in_fire) st_nxt = FE_RUN;
      FE_RUN:  if (cnt_r == LAST_CNT) st_nxt = FE_PUSH;
      FE_PUSH: begin
        if (q_ready) st_nxt = in_fire ? FE_RUN : FE_IDLE;
      end
      default: st_nxt = FE_IDLE;
    endcase
  end

  always_comb begin
    in_ready = (st_r == FE_IDLE) || ((st_r == FE_PUSH) && q_ready);
    q_valid  = (st_r == FE_PUSH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) st_r <= FE_IDLE;
    else        st_r <= st_nxt;
  end

  // Load values.
  logic [14:0] thr_e;
  logic signed [16:0] d_s, mag_s, xa, ya, xb, yb;
  logic [15:0] mag, dif;
  assign thr_e = (thr == 15'd0) ? 15'd1 : thr;
  assign d_s   = {sd[15], sd};
  assign mag_s = d_s[16] ? -d_s : d_s;
  assign mag   = mag_s[15:0];
  assign dif   = mag - {1'b0, near_tol};
  assign xa    = -{gy[15], gy};
  assign ya    = {gx[15], gx};
  assign xb    = xa[16] ? -xa : xa;
  assign yb    = xa[16] ? -ya : ya;

  // Two CORDIC steps per cycle.
  logic signed [CW_W-1:0] x1, y1, x2, y2;
  logic signed [ZW_W-1:0] z1, z2;
  logic [4:0] i0, i1;
  assign i0 = {cnt_r, 1'b0};
  assign i1 = {cnt_r, 1'b1};
  always_comb begin
    if (!y_r[CW_W-1]) begin
      x1 = x_r + (y_r >>> i0);
      y1 = y_r - (x_r >>> i0);
      z1 = z_r + atan_val(i0);
    end else begin
      x1 = x_r - (y_r >>> i0);
      y1 = y_r + (x_r >>> i0);
      z1 = z_r - atan_val(i0);
    end
    if (!y1[CW_W-1]) begin
      x2 = x1 + (y1 >>> i1);
      y2 = y1 - (x1 >>> i1);
      z2 = z1 + atan_val(i1);
    end else begin
      x2 = x1 - (y1 >>> i1);
      y2 = y1 + (x1 >>> i1);
      z2 = z1 - atan_val(i1);
    end
  end

  // One restoring division bit per cycle.
  logic [16:0] rem2, rem_sub;
  logic ge;
  assign rem2    = {rem_r, 1'b0};
  assign ge      = rem2 >= {2'b00, thr_e};
  assign rem_sub = rem2 - {2'b00, thr_e};

  always_ff @(posedge clk) begin
    if (in_fire) begin
      cnt_r       <= '0;
      far_r       <= mag > {1'b0, thr_e};
      near_r      <= mag < {1'b0, near_tol};
      sat_r       <= dif >= {1'b0, thr_e};
      rem_r       <= dif;
      quo_r       <= '0;
      axis_r      <= (xb == 17'sd0);
      axis_zero_r <= (yb == 17'sd0);
      x_r         <= {{(CW_W-33){xb[16]}}, xb, 16'd0};
      y_r         <= {{(CW_W-33){yb[16]}}, yb, 16'd0};
      z_r         <= '0;
    end else if (st_r == FE_RUN) begin
      cnt_r <= cnt_r + 4'd1;
      rem_r <= ge ? rem_sub[15:0] : rem2[15:0];
      quo_r <= {quo_r[13:0], ge};
      if (cnt_r != LAST_CNT) begin
        x_r <= x2;
        y_r <= y2;
        z_r <= z2;
      end
    end
  end

  logic signed [ZW_W-1:0] z_rnd, z_sh;
  assign z_rnd = z_r + 34'sd16384;
  assign z_sh  = z_rnd >>> 15;

  always_comb begin
    q_data.far  = far_r;
    q_data.cham = near_r ? 16'd0 : (sat_r ? ONE_Q15 : {1'b0, quo_r});
    if (axis_r) q_data.ang = axis_zero_r ? 16'd0 : HALF_TURN;
    else        q_data.ang = z_sh[15:0];
  end

endmodule

// ===== rtl/occ_queue.sv =====
// Short register queue between the front and back parts.
`timescale 1ns / 1ps
module occ_queue import occ_pkg::*; (
  input  logic  clk,
  input  logic  rst_n,
  input  logic  wr_valid,
  output logic  wr_ready,
  input  qent_t wr_data,
  output logic  rd_valid,
  input  logic  rd_ready,
  output qent_t rd_data
);

  localparam int PW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

  qent_t mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r;
  logic wr_fire, rd_fire;

  assign wr_ready = cnt_r != CW'(QUEUE_DEPTH);
  assign rd_valid = cnt_r != '0;
  assign rd_data  = mem_r[rp_r];
  assign wr_fire  = wr_valid && wr_ready;
  assign rd_fire  = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr_fire) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_fire) wp_r <= (wp_r == PTR_LAST) ? '0 : wp_r + PW'(1);
      if (rd_fire) rp_r <= (rp_r == PTR_LAST) ? '0 : rp_r + PW'(1);
      if (wr_fire && !rd_fire)      cnt_r <= cnt_r + CW'(1);
      else if (rd_fire && !wr_fire) cnt_r <= cnt_r - CW'(1);
    end
  end

endmodule

// ===== rtl/occ_back.sv =====
// Back part: walks the orientation channels of a pixel and drives the result register.
`timescale 1ns / 1ps
module occ_back import occ_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic [CNT_W-1:0]      n,
  input  logic                  q_valid,
  output logic                  q_ready,
  input  qent_t                 q_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [CH_W-1:0]       ch,
  output logic [COST_W-1:0]     cham,
  output logic [COST_W-1:0]     orient,
  output logic                  last
);

  qent_t ent_r;
  logic act_r, ov_r, last_r;
  logic [CNT_W-1:0] c_r, rem_r;
  logic [15:0] a_r;
  logic [CH_W-1:0] ch_r;
  logic [COST_W-1:0] cham_r, oc_r;

  logic load, is_last, pop;
  assign load    = act_r && (!ov_r || out_ready);
  assign is_last = c_r == (n - CNT_W'(1));
  assign pop     = q_valid && (!act_r || (load && is_last));
  assign q_ready = !act_r || (load && is_last);

  logic [15:0] diff, f, quo;
  logic [CNT_W-1:0] rstep;
  logic [CNT_W:0] rsum;
  assign diff  = a_r - ent_r.ang;
  assign f     = (diff > HALF_TURN) ? (16'd0 - diff) : diff;
  assign quo   = step_quo(n);
  assign rstep = step_rem(n);
  assign rsum  = {1'b0, rem_r} + {1'b0, rstep};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r <= 1'b0;
      ov_r  <= 1'b0;
    end else begin
      if (pop)                  act_r <= 1'b1;
      else if (load && is_last) act_r <= 1'b0;
      if (load)           ov_r <= 1'b1;
      else if (out_ready) ov_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      ent_r <= q_data;
      c_r   <= '0;
      a_r   <= '0;
      rem_r <= n >> 1;
    end else if (load) begin
      c_r <= c_r + CNT_W'(1);
      if (rsum >= {1'b0, n}) begin
        rem_r <= CNT_W'(rsum - {1'b0, n});
        a_r   <= a_r + quo + 16'd1;
      end else begin
        rem_r <= rsum[CNT_W-1:0];
        a_r   <= a_r + quo;
      end
    end
    if (load) begin
      ch_r   <= c_r[CH_W-1:0];
      cham_r <= ent_r.cham;
      oc_r   <= ent_r.far ? ONE_Q15 : f;
      last_r <= is_last;
    end
  end

  assign out_valid = ov_r;
  assign ch        = ch_r;
  assign cham      = cham_r;
  assign orient    = oc_r;
  assign last      = last_r;

endmodule
